[design/assert_macros.svh]
// Assertion helpers used by the checker file ccl_checker.sv.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition never holds on a rising clock edge outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[design/ccl_pkg.sv]
package ccl_pkg;

  // Kept line positions; only these take part in classification
  localparam int unsigned HeadDepth = 16;
  localparam int unsigned HeadIdxW  = 4;

  // Result codes
  typedef enum logic [3:0] {
    RES_SETDATE_OK = 4'd0,
    RES_SETTIME_OK = 4'd1,
    RES_GETDATE    = 4'd2,
    RES_GETTIME    = 4'd3,
    RES_HELP       = 4'd4,
    RES_BAD_DIGITS = 4'd5,
    RES_DATE_RANGE = 4'd6,
    RES_TIME_RANGE = 4'd7,
    RES_UNKNOWN    = 4'd8
  } result_e;

  // Command words, first character in the top byte
  localparam logic [55:0] WORD_SETDATE = "setdate";
  localparam logic [55:0] WORD_SETTIME = "settime";
  localparam logic [55:0] WORD_GETDATE = "getdate";
  localparam logic [55:0] WORD_GETTIME = "gettime";
  localparam logic [31:0] WORD_HELP    = "help";

  localparam logic [7:0] CHAR_0 = 8'h30;
  localparam logic [7:0] CHAR_9 = 8'h39;

  localparam logic [7:0] LINE_END_RESET = 8'd10;

  localparam logic [6:0] HOURS_LIMIT   = 7'd24;
  localparam logic [6:0] MINUTES_LIMIT = 7'd60;

  function automatic logic is_digit(logic [7:0] b);
    return (b >= CHAR_0) && (b <= CHAR_9);
  endfunction

  // Two decimal digits to a value 0..99
  function automatic logic [6:0] pair_value(logic [7:0] hi, logic [7:0] lo);
    logic [6:0] h;
    logic [6:0] l;
    h = {3'd0, hi[3:0]};
    l = {3'd0, lo[3:0]};
    return (h << 3) + (h << 1) + l;
  endfunction

  // Month length for months 1..12, February at 29
  function automatic logic [6:0] month_days(logic [3:0] month);
    logic [6:0] d;
    unique case (month)
      4'd2:                   d = 7'd29;
      4'd4, 4'd6, 4'd9, 4'd11: d = 7'd30;
      default:                d = 7'd31;
    endcase
    return d;
  endfunction

endpackage

[design/clock_command_line_parser_unit.sv]
// Console command line parser.
// Slave stream: one received console byte per beat in s_axis_tdata_i[7:0].
// The first 16 bytes of a line are stored until the byte held in the line end register arrives
// (cfg_we_i/cfg_wdata_i, 10 after reset); that beat classifies the line and
// yields one result beat on the master stream, all other bytes yield none.
// Master stream: tdata carries line_result, then the three parsed two-digit
// values (day/month/year or hours/minutes/seconds), zero when not parsed.
// Timing: the edge that accepts the line end beat stores it in the line
// store and sets the pending flag; the output register is loaded from the
// classifier when it is free, so the result beat follows the line end beat.
// Throughput: one byte per cycle while s_axis_tready_o is high; the line end
// beat is registered and the classifier (five command word compares, digit
// conversion, range checks) sits between that register and the output register.
// Reset clears the line store, write position, pending line end and output valid.
// When the receiver stalls, the result waits in the output register and
// bytes keep flowing; once a second line end is accepted behind a stalled
// result, s_axis_tready_o drops until the output register is taken.
module clock_command_line_parser_unit #(
  parameter int unsigned LINE_CAPACITY = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [7:0]  cfg_wdata_i,
  // tdata: [7:0] rx_byte
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,
  // tdata: [3:0] line_result, [10:4] first_value, [17:11] second_value,
  //        [24:18] third_value, [31:25] zero
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [31:0] m_axis_tdata_o
);

  localparam int unsigned PosW = $clog2(LINE_CAPACITY);
  localparam logic [PosW-1:0] PosLast = PosW'(LINE_CAPACITY - 1);

  logic [7:0]      line_end_q;
  logic [7:0]      head_q [ccl_pkg::HeadDepth];
  logic [PosW-1:0] pos_q;
  logic            pending_q;
  logic            out_valid_q;
  logic [31:0]     out_data_q;

  logic            in_fire;
  logic            is_end;
  logic            pos_in_head;
  logic [ccl_pkg::HeadIdxW-1:0] head_idx;
  logic            slot_free;
  logic            advance;

  // Stall input only while a classified line cannot move on
  assign slot_free       = !out_valid_q || m_axis_tready_i;
  assign advance         = pending_q && slot_free;
  assign s_axis_tready_o = !pending_q || slot_free;
  assign in_fire         = s_axis_tvalid_i && s_axis_tready_o;
  assign is_end          = (s_axis_tdata_i == line_end_q);
  assign pos_in_head     = (pos_q < PosW'(ccl_pkg::HeadDepth));
  assign head_idx        = pos_q[ccl_pkg::HeadIdxW-1:0];

  // Configuration register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_end_q <= ccl_pkg::LINE_END_RESET;
    end else if (cfg_we_i) begin
      line_end_q <= cfg_wdata_i;
    end
  end

  // Line store and write position: store each byte within the kept head positions, a zero on line end
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ccl_pkg::HeadDepth; i++) begin
        head_q[i] <= 8'd0;
      end
      pos_q     <= '0;
      pending_q <= 1'b0;
    end else begin
      if (in_fire) begin
        if (pos_in_head) begin
          head_q[head_idx] <= is_end ? 8'd0 : s_axis_tdata_i;
        end
        if (is_end) begin
          pos_q <= '0;
        end else if (pos_q < PosLast) begin
          pos_q <= pos_q + 1'b1;
        end
      end
      if (in_fire && is_end) begin
        pending_q <= 1'b1;
      end else if (advance) begin
        pending_q <= 1'b0;
      end
    end
  end

  // Classify the stored line
  logic        m_setdate, m_settime, m_getdate, m_gettime, m_help;
  logic        digits_ok;
  logic [6:0]  v1, v2, v3;
  logic        date_ok, time_ok;
  ccl_pkg::result_e res;
  logic [6:0]  o1, o2, o3;

  always_comb begin
    m_setdate = {head_q[0], head_q[1], head_q[2], head_q[3],
                 head_q[4], head_q[5], head_q[6]} == ccl_pkg::WORD_SETDATE;
    m_settime = {head_q[0], head_q[1], head_q[2], head_q[3],
                 head_q[4], head_q[5], head_q[6]} == ccl_pkg::WORD_SETTIME;
    m_getdate = {head_q[0], head_q[1], head_q[2], head_q[3],
                 head_q[4], head_q[5], head_q[6]} == ccl_pkg::WORD_GETDATE;
    m_gettime = {head_q[0], head_q[1], head_q[2], head_q[3],
                 head_q[4], head_q[5], head_q[6]} == ccl_pkg::WORD_GETTIME;
    m_help    = {head_q[0], head_q[1], head_q[2], head_q[3]} == ccl_pkg::WORD_HELP;

    digits_ok = ccl_pkg::is_digit(head_q[8])  && ccl_pkg::is_digit(head_q[9])  &&
                ccl_pkg::is_digit(head_q[11]) && ccl_pkg::is_digit(head_q[12]) &&
                ccl_pkg::is_digit(head_q[14]) && ccl_pkg::is_digit(head_q[15]);

    v1 = ccl_pkg::pair_value(head_q[8],  head_q[9]);
    v2 = ccl_pkg::pair_value(head_q[11], head_q[12]);
    v3 = ccl_pkg::pair_value(head_q[14], head_q[15]);

    date_ok = (v2 >= 7'd1) && (v2 <= 7'd12) && (v1 >= 7'd1) &&
              (v1 <= ccl_pkg::month_days(v2[3:0]));
    time_ok = (v1 < ccl_pkg::HOURS_LIMIT) && (v2 < ccl_pkg::MINUTES_LIMIT) &&
              (v3 < ccl_pkg::MINUTES_LIMIT);

    o1 = 7'd0;
    o2 = 7'd0;
    o3 = 7'd0;
    if (m_setdate || m_settime) begin
      if (!digits_ok) begin
        res = ccl_pkg::RES_BAD_DIGITS;
      end else begin
        o1 = v1;
        o2 = v2;
        o3 = v3;
        if (m_setdate) begin
          res = date_ok ? ccl_pkg::RES_SETDATE_OK : ccl_pkg::RES_DATE_RANGE;
        end else begin
          res = time_ok ? ccl_pkg::RES_SETTIME_OK : ccl_pkg::RES_TIME_RANGE;
        end
      end
    end else if (m_getdate) begin
      res = ccl_pkg::RES_GETDATE;
    end else if (m_gettime) begin
      res = ccl_pkg::RES_GETTIME;
    end else if (m_help) begin
      res = ccl_pkg::RES_HELP;
    end else begin
      res = ccl_pkg::RES_UNKNOWN;
    end
  end

  // Output register: load on advance, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_data_q <= {7'd0, o3, o2, o1, res};
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

endmodule

[design/ccl_checker.sv]
`include "assert_macros.svh"

module ccl_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [31:0] m_axis_tdata_o
);

  logic [3:0]  res_code;
  logic [32:0] out_beat;
  logic        out_stall;
  logic        code_bad;
  logic        no_values;
  logic        vals_clear;

  assign res_code   = m_axis_tdata_o[3:0];
  assign out_beat   = {m_axis_tvalid_o, m_axis_tdata_o};
  assign out_stall  = m_axis_tvalid_o && !m_axis_tready_i;
  assign code_bad   = (res_code > ccl_pkg::RES_UNKNOWN);
  assign no_values  = (res_code == ccl_pkg::RES_GETDATE) ||
                      (res_code == ccl_pkg::RES_GETTIME) ||
                      (res_code == ccl_pkg::RES_HELP) ||
                      (res_code == ccl_pkg::RES_BAD_DIGITS) ||
                      (res_code == ccl_pkg::RES_UNKNOWN);
  assign vals_clear = (m_axis_tdata_o[24:4] == 21'd0);

  // A stalled result beat holds
  `ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_stall |=> $stable(out_beat), "stalled result changed")

  // Result code stays within the defined codes
  `ASSERT_NEVER(a_res_range, clk_i, rst_ni, m_axis_tvalid_o && code_bad, "result code out of range")

  // Values are zero unless the line was a parsed set command
  `ASSERT_CLK(a_vals_zero, clk_i, rst_ni, m_axis_tvalid_o && no_values |-> vals_clear, "values not zero")

  // Input is only held off behind a stalled result
  `ASSERT_CLK(a_ready_stall, clk_i, rst_ni, !s_axis_tready_o |-> out_stall, "input held off")

endmodule

bind clock_command_line_parser_unit ccl_checker u_ccl_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
